>>> rtl/agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg
// Shared widths, constants and unit request/response types for the
// peak-based automatic gain control block.
// ----------------------------------------------------------------------------
package agc_pkg;

  // field widths
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W       = 6 + GAIN_FRAC_BITS;
  localparam int PROD_W       = GAIN_W + SAMPLE_W;
  localparam int COUNT_W      = 12;
  localparam int LEVEL_W      = 15;
  localparam int BLOCKS_W     = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 15;

  // divider geometry: dividend holds TARGET_LEVEL << GAIN_FRAC_BITS
  localparam int TARGET_LEVEL = 31129;
  localparam int DIVIDEND_W   = LEVEL_W + GAIN_FRAC_BITS;
  localparam int DIVISOR_W    = SAMPLE_W;

  // serial unit counters
  localparam int MUL_CNT_W    = $clog2(SAMPLE_W);
  localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);

  // gain constants
  localparam logic [GAIN_W-1:0]     GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0]     GAIN_MAX   = '1;
  localparam logic [DIVIDEND_W-1:0] TARGET_NUM =
    DIVIDEND_W'(TARGET_LEVEL) << GAIN_FRAC_BITS;
  localparam logic [SAMPLE_W-1:0]   DECAY_MUL  = SAMPLE_W'(19);
  localparam logic [DIVISOR_W-1:0]  DECAY_DIV  = DIVISOR_W'(20);
  localparam logic [DIVISOR_W-1:0]  SLOW_DIV   = DIVISOR_W'(20);

  // counters and levels
  localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;
  localparam logic [BLOCKS_W-1:0]   BLOCKS_MAX = '1;
  localparam logic [SAMPLE_W-1:0]   PEAK_RESET = SAMPLE_W'(1);
  localparam logic [SAMPLE_W-1:0]   POS_LIMIT  = SAMPLE_W'(32767);
  localparam logic [SAMPLE_W-1:0]   NEG_LIMIT  = SAMPLE_W'(32768);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_AFTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_AFTER   = 3'd4;

  // configuration reset values
  localparam logic [COUNT_W-1:0]  BLOCK_LENGTH_RST = 12'd800;
  localparam logic [LEVEL_W-1:0]  SPEECH_LEVEL_RST = 15'd800;
  localparam logic [LEVEL_W-1:0]  CLIP_LEVEL_RST   = 15'd32000;
  localparam logic [BLOCKS_W-1:0] DECAY_AFTER_RST  = 8'd20;
  localparam logic [BLOCKS_W-1:0] FAST_AFTER_RST   = 8'd40;

  // multiplier request and response
  typedef struct packed {
    logic                start;
    logic [GAIN_W-1:0]   a;
    logic [SAMPLE_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/automatic_gain_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// automatic_gain_control_core
// Peak-based automatic gain control for signed 16-bit samples.
//
// Usage: in_valid/in_stall/in_sample_in carries one sample per transaction;
//   out_valid/out_stall/out_sample_out returns exactly one scaled sample per
//   input, in order. cfg_valid/cfg_ready/cfg_index/cfg_data writes the five
//   control registers; cfg_ready is always high, and writes belong in idle
//   periods.
// Sequence: a bit-serial multiplier and a bit-serial divider do the arithmetic.
//   A plain sample takes one multiplication for the clip check and one for the
//   output; a clip or a quarter-step update adds one division, a slow update
//   two divisions and a decay update a multiplication and a division. One sample
//   is in work at a time; in_stall is high while it runs and drops as the result
//   is loaded into the output register.
// Reset: synchronous, active low; gain, peak, counters and registers go to defaults.
// Stall: the result sits in an output register; the next sample is accepted
//   while it waits, and its own result holds in the multiplier until the
//   output register frees up.
// ----------------------------------------------------------------------------
module automatic_gain_control_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [agc_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [agc_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [agc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [agc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_MUL_CLIP  = 7'b0000010,
    ST_DIV_TGT   = 7'b0000100,
    ST_DIV_STEP  = 7'b0001000,
    ST_MUL_DECAY = 7'b0010000,
    ST_DIV_DECAY = 7'b0100000,
    ST_MUL_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [agc_pkg::COUNT_W-1:0]  block_length_r;
  logic [agc_pkg::LEVEL_W-1:0]  speech_level_r;
  logic [agc_pkg::LEVEL_W-1:0]  clip_level_r;
  logic [agc_pkg::BLOCKS_W-1:0] decay_after_r;
  logic [agc_pkg::BLOCKS_W-1:0] fast_after_r;

  // gain state
  logic [agc_pkg::SAMPLE_W-1:0] peak_r, peak_nxt;
  logic [agc_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [agc_pkg::GAIN_W-1:0]   gain_r, gain_nxt;
  logic [agc_pkg::BLOCKS_W-1:0] silent_r, silent_nxt;

  // per-transaction working registers
  logic [agc_pkg::SAMPLE_W-1:0] mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic                         speech_r, speech_nxt;
  logic                         dneg_r, dneg_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [agc_pkg::SAMPLE_W-1:0] out_data_r, out_data_nxt;

  agc_pkg::mul_req_t mul_req;
  agc_pkg::mul_rsp_t mul_rsp;
  agc_pkg::div_req_t div_req;
  agc_pkg::div_rsp_t div_rsp;

  logic [agc_pkg::SAMPLE_W-1:0] in_mag;
  logic [agc_pkg::BLOCKS_W-1:0] silent_inc;
  logic [agc_pkg::GAIN_W-1:0]   target;
  logic [agc_pkg::GAIN_W-1:0]   dmag;
  logic                         tneg;
  logic [agc_pkg::GAIN_W-1:0]   scaled;
  logic                         start_out;

  agc_mul_serial u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  agc_div_serial u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // operand shaping
  always_comb begin
    in_mag = in_sample_in[agc_pkg::SAMPLE_W-1] ? (~in_sample_in + 1'b1) : in_sample_in;
    silent_inc = (silent_r == agc_pkg::BLOCKS_MAX) ? silent_r : silent_r + 1'b1;
    target = (div_rsp.quo[agc_pkg::DIVIDEND_W-1:agc_pkg::GAIN_W] != '0) ?
             agc_pkg::GAIN_MAX : div_rsp.quo[agc_pkg::GAIN_W-1:0];
    tneg   = target < gain_r;
    dmag   = tneg ? (gain_r - target) : (target - gain_r);
    scaled = mul_rsp.prod[agc_pkg::PROD_W-1:agc_pkg::GAIN_FRAC_BITS];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    peak_nxt      = peak_r;
    count_nxt     = count_r;
    gain_nxt      = gain_r;
    silent_nxt    = silent_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    speech_nxt    = speech_r;
    dneg_nxt      = dneg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_req       = '0;
    div_req       = '0;
    start_out     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt   = in_mag;
          neg_nxt   = in_sample_in[agc_pkg::SAMPLE_W-1];
          peak_nxt  = (in_mag > peak_r) ? in_mag : peak_r;
          count_nxt = (count_r == agc_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
          mul_req   = '{start: 1'b1, a: gain_r, b: in_mag};
          state_nxt = ST_MUL_CLIP;
        end
      end
      ST_MUL_CLIP: begin
        if (mul_rsp.done) begin
          if (mul_rsp.prod > {clip_level_r, agc_pkg::GAIN_FRAC_BITS'(0)}) begin
            // clip: recompute the gain from the peak right away
            div_req    = '{start: 1'b1, dividend: agc_pkg::TARGET_NUM, divisor: peak_r};
            speech_nxt = 1'b0;
            state_nxt  = ST_DIV_TGT;
          end else if (count_r >= block_length_r) begin
            count_nxt = '0;
            peak_nxt  = agc_pkg::PEAK_RESET;
            if (peak_r > {1'b0, speech_level_r}) begin
              div_req    = '{start: 1'b1, dividend: agc_pkg::TARGET_NUM, divisor: peak_r};
              speech_nxt = 1'b1;
              state_nxt  = ST_DIV_TGT;
            end else begin
              silent_nxt = silent_inc;
              if (gain_r > agc_pkg::GAIN_ONE && silent_inc >= decay_after_r) begin
                mul_req   = '{start: 1'b1, a: gain_r, b: agc_pkg::DECAY_MUL};
                state_nxt = ST_MUL_DECAY;
              end else begin
                start_out = 1'b1;
              end
            end
          end else begin
            start_out = 1'b1;
          end
        end
      end
      ST_DIV_TGT: begin
        if (div_rsp.done) begin
          if (!speech_r) begin
            gain_nxt   = target;
            silent_nxt = '0;
            start_out  = 1'b1;
          end else if (silent_r > fast_after_r) begin
            // quarter step, truncated toward zero
            gain_nxt   = tneg ? gain_r - (dmag >> 2) : gain_r + (dmag >> 2);
            silent_nxt = '0;
            start_out  = 1'b1;
          end else begin
            dneg_nxt  = tneg;
            div_req   = '{start: 1'b1,
                          dividend: agc_pkg::DIVIDEND_W'(dmag),
                          divisor: agc_pkg::SLOW_DIV};
            state_nxt = ST_DIV_STEP;
          end
        end
      end
      ST_DIV_STEP: begin
        if (div_rsp.done) begin
          gain_nxt   = dneg_r ? gain_r - div_rsp.quo[agc_pkg::GAIN_W-1:0]
                              : gain_r + div_rsp.quo[agc_pkg::GAIN_W-1:0];
          silent_nxt = '0;
          start_out  = 1'b1;
        end
      end
      ST_MUL_DECAY: begin
        if (mul_rsp.done) begin
          div_req   = '{start: 1'b1,
                        dividend: mul_rsp.prod[agc_pkg::DIVIDEND_W-1:0],
                        divisor: agc_pkg::DECAY_DIV};
          state_nxt = ST_DIV_DECAY;
        end
      end
      ST_DIV_DECAY: begin
        if (div_rsp.done) begin
          gain_nxt  = div_rsp.quo[agc_pkg::GAIN_W-1:0];
          start_out = 1'b1;
        end
      end
      ST_MUL_OUT: begin
        if (mul_rsp.done && (!out_valid_r || !out_stall)) begin
          if (neg_r) begin
            out_data_nxt = (scaled > agc_pkg::GAIN_W'(agc_pkg::NEG_LIMIT)) ?
                           agc_pkg::NEG_LIMIT : (~scaled[agc_pkg::SAMPLE_W-1:0] + 1'b1);
          end else begin
            out_data_nxt = (scaled > agc_pkg::GAIN_W'(agc_pkg::POS_LIMIT)) ?
                           agc_pkg::POS_LIMIT : scaled[agc_pkg::SAMPLE_W-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // final scaling uses the gain as it stands after this transaction's update
    if (start_out) begin
      mul_req   = '{start: 1'b1, a: gain_nxt, b: mag_r};
      state_nxt = ST_MUL_OUT;
    end
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      peak_r         <= agc_pkg::PEAK_RESET;
      count_r        <= '0;
      gain_r         <= agc_pkg::GAIN_ONE;
      silent_r       <= '0;
      out_valid_r    <= 1'b0;
      block_length_r <= agc_pkg::BLOCK_LENGTH_RST;
      speech_level_r <= agc_pkg::SPEECH_LEVEL_RST;
      clip_level_r   <= agc_pkg::CLIP_LEVEL_RST;
      decay_after_r  <= agc_pkg::DECAY_AFTER_RST;
      fast_after_r   <= agc_pkg::FAST_AFTER_RST;
    end else begin
      state_r     <= state_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      gain_r      <= gain_nxt;
      silent_r    <= silent_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          agc_pkg::REG_BLOCK_LENGTH: block_length_r <= cfg_data[agc_pkg::COUNT_W-1:0];
          agc_pkg::REG_SPEECH_LEVEL: speech_level_r <= cfg_data[agc_pkg::LEVEL_W-1:0];
          agc_pkg::REG_CLIP_LEVEL:   clip_level_r   <= cfg_data[agc_pkg::LEVEL_W-1:0];
          agc_pkg::REG_DECAY_AFTER:  decay_after_r  <= cfg_data[agc_pkg::BLOCKS_W-1:0];
          agc_pkg::REG_FAST_AFTER:   fast_after_r   <= cfg_data[agc_pkg::BLOCKS_W-1:0];
          default: ;
        endcase
      end
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    speech_r   <= speech_nxt;
    dneg_r     <= dneg_nxt;
    out_data_r <= out_data_nxt;
  end

  // ports
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign cfg_ready      = 1'b1;

endmodule

>>> rtl/agc_mul_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_mul_serial
// Shift-add multiplier, one multiplier bit per cycle. The product holds
// in the shift register until the next start.
// ----------------------------------------------------------------------------
module agc_mul_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  agc_pkg::mul_req_t req,
  output agc_pkg::mul_rsp_t rsp
);

  logic [agc_pkg::GAIN_W-1:0]    a_r,  a_nxt;
  logic [agc_pkg::GAIN_W-1:0]    hi_r, hi_nxt;
  logic [agc_pkg::SAMPLE_W-1:0]  lo_r, lo_nxt;
  logic [agc_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [agc_pkg::GAIN_W:0]      sum;

  // one partial product per cycle, shifted right into the low half
  always_comb begin
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    if (req.start) begin
      a_nxt    = req.a;
      hi_nxt   = '0;
      lo_nxt   = req.b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[agc_pkg::GAIN_W:1];
      lo_nxt  = {sum[0], lo_r[agc_pkg::SAMPLE_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == agc_pkg::MUL_CNT_W'(agc_pkg::SAMPLE_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign rsp.done = !busy_r;
  assign rsp.prod = {hi_r, lo_r};

endmodule

>>> rtl/agc_div_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_div_serial
// Restoring divider, one quotient bit per cycle. The quotient holds
// in the shift register until the next start.
// ----------------------------------------------------------------------------
module agc_div_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  agc_pkg::div_req_t req,
  output agc_pkg::div_rsp_t rsp
);

  logic [agc_pkg::DIVISOR_W-1:0]  den_r, den_nxt;
  logic [agc_pkg::DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [agc_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [agc_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic [agc_pkg::DIVISOR_W:0]    shifted;
  logic [agc_pkg::DIVISOR_W+1:0]  trial;

  // shift one dividend bit into the remainder, subtract when it fits
  always_comb begin
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, quo_r[agc_pkg::DIVIDEND_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    if (req.start) begin
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[agc_pkg::DIVISOR_W+1]) begin
        rem_nxt = shifted[agc_pkg::DIVISOR_W-1:0];
        quo_nxt = {quo_r[agc_pkg::DIVIDEND_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[agc_pkg::DIVISOR_W-1:0];
        quo_nxt = {quo_r[agc_pkg::DIVIDEND_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == agc_pkg::DIV_CNT_W'(agc_pkg::DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = !busy_r;
  assign rsp.quo  = quo_r;

endmodule

>>> rtl/agc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_checker
// Port-level checks on the automatic gain control core, bound to the
// top level.
// ----------------------------------------------------------------------------
module agc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [agc_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                         cfg_ready
);

  // no result shows right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one transaction at a time: the input closes after each accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted transaction");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind automatic_gain_control_core agc_checker u_agc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .cfg_ready      (cfg_ready)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for automatic_gain_control_core. A behavioral gain model
// predicts every scaled sample at input acceptance, and a checker compares
// each output transaction in order. Tests cover reset defaults, register
// extremes, silence decay, a clip run that holds a block update back,
// back-pressure, and random speech and silence bursts under random idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 3_000_000;
  // index outside the register map, writes to it are ignored
  localparam logic [agc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [agc_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [agc_pkg::SAMPLE_W-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [agc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [agc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 35;
  int stall_hold = 0;
  int errors = 0;
  int cycle_count = 0;

  // gain model configuration
  logic [agc_pkg::COUNT_W-1:0] len_reg = agc_pkg::BLOCK_LENGTH_RST;
  logic [agc_pkg::LEVEL_W-1:0] speech_reg = agc_pkg::SPEECH_LEVEL_RST;
  logic [agc_pkg::LEVEL_W-1:0] clip_reg = agc_pkg::CLIP_LEVEL_RST;
  logic [agc_pkg::BLOCKS_W-1:0] decay_reg = agc_pkg::DECAY_AFTER_RST;
  logic [agc_pkg::BLOCKS_W-1:0] fast_reg = agc_pkg::FAST_AFTER_RST;

  // gain model state
  logic [agc_pkg::SAMPLE_W-1:0] peak_mag = agc_pkg::PEAK_RESET;
  logic [agc_pkg::COUNT_W-1:0] blk_count = '0;
  logic [agc_pkg::GAIN_W-1:0] gain_q = agc_pkg::GAIN_ONE;
  logic [agc_pkg::BLOCKS_W-1:0] quiet_blocks = '0;

  logic signed [agc_pkg::SAMPLE_W-1:0] expected_out[$];
  logic signed [agc_pkg::SAMPLE_W-1:0] want_sample;

  automatic_gain_control_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // target gain for a peak, clamped to the largest gain
  function automatic logic [agc_pkg::GAIN_W-1:0] target_gain_of(
    input logic [agc_pkg::SAMPLE_W-1:0] pk);
    logic [63:0] quo;
    quo = (64'(agc_pkg::TARGET_LEVEL) << agc_pkg::GAIN_FRAC_BITS) /
          ((pk == '0) ? 64'd1 : 64'(pk));
    if (quo > 64'(agc_pkg::GAIN_MAX)) return agc_pkg::GAIN_MAX;
    return quo[agc_pkg::GAIN_W-1:0];
  endfunction

  // end of block: move toward target on speech, count and decay on silence
  function automatic void update_block_gain();
    longint delta;
    longint step;
    if (peak_mag > agc_pkg::SAMPLE_W'(speech_reg)) begin
      delta = longint'(64'(target_gain_of(peak_mag))) - longint'(64'(gain_q));
      step = (quiet_blocks > fast_reg) ? delta / 4 : delta / 20;
      gain_q = agc_pkg::GAIN_W'(longint'(64'(gain_q)) + step);
      quiet_blocks = '0;
    end else begin
      if (quiet_blocks != agc_pkg::BLOCKS_MAX) quiet_blocks++;
      if (gain_q > agc_pkg::GAIN_ONE && quiet_blocks >= decay_reg)
        gain_q = agc_pkg::GAIN_W'((64'(gain_q) * 64'd19) / 64'd20);
    end
    blk_count = '0;
    peak_mag = agc_pkg::PEAK_RESET;
  endfunction

  // advance the gain model by one sample and return the scaled sample
  function automatic logic signed [agc_pkg::SAMPLE_W-1:0] predict_scaled(
    input logic signed [agc_pkg::SAMPLE_W-1:0] smp);
    logic neg;
    logic [agc_pkg::SAMPLE_W-1:0] mag;
    logic [63:0] prod;
    neg = smp[agc_pkg::SAMPLE_W-1];
    mag = neg ? (~smp + 1'b1) : smp;
    if (mag > peak_mag) peak_mag = mag;
    if (blk_count != agc_pkg::COUNT_MAX) blk_count++;
    if (64'(mag) * 64'(gain_q) > (64'(clip_reg) << agc_pkg::GAIN_FRAC_BITS)) begin
      gain_q = target_gain_of(peak_mag);
      quiet_blocks = '0;
    end else if (blk_count >= len_reg) begin
      update_block_gain();
    end
    prod = (64'(mag) * 64'(gain_q)) >> agc_pkg::GAIN_FRAC_BITS;
    if (neg) begin
      if (prod > 64'd32768) prod = 64'd32768;
      return agc_pkg::SAMPLE_W'(64'd65536 - prod);
    end
    if (prod > 64'd32767) prod = 64'd32767;
    return agc_pkg::SAMPLE_W'(prod);
  endfunction

  function automatic logic signed [agc_pkg::SAMPLE_W-1:0] with_sign(input int mag);
    return ($urandom_range(1) == 1) ? agc_pkg::SAMPLE_W'(-mag) : agc_pkg::SAMPLE_W'(mag);
  endfunction

  function automatic logic signed [agc_pkg::SAMPLE_W-1:0] edge_sample();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // one input transaction, entered and left at a falling edge
  task automatic send_sample(input logic signed [agc_pkg::SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_out.push_back(predict_scaled(smp));
    @(negedge clk);
  endtask

  // one register write transaction, valid is left high for the next one
  task automatic write_reg(input logic [agc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [agc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      agc_pkg::REG_BLOCK_LENGTH: len_reg = data[agc_pkg::COUNT_W-1:0];
      agc_pkg::REG_SPEECH_LEVEL: speech_reg = data[agc_pkg::LEVEL_W-1:0];
      agc_pkg::REG_CLIP_LEVEL: clip_reg = data[agc_pkg::LEVEL_W-1:0];
      agc_pkg::REG_DECAY_AFTER: decay_reg = data[agc_pkg::BLOCKS_W-1:0];
      agc_pkg::REG_FAST_AFTER: fast_reg = data[agc_pkg::BLOCKS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input int len, input int speech, input int clip,
                            input int decay, input int fast);
    write_reg(agc_pkg::REG_BLOCK_LENGTH, agc_pkg::CFG_DATA_W'(len));
    write_reg(agc_pkg::REG_SPEECH_LEVEL, agc_pkg::CFG_DATA_W'(speech));
    write_reg(agc_pkg::REG_CLIP_LEVEL, agc_pkg::CFG_DATA_W'(clip));
    write_reg(agc_pkg::REG_DECAY_AFTER, agc_pkg::CFG_DATA_W'(decay));
    write_reg(agc_pkg::REG_FAST_AFTER, agc_pkg::CFG_DATA_W'(fast));
    cfg_valid <= 1'b0;
  endtask

  // stop offering samples and wait until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // reset register values, field extremes and a clip at full scale
  task automatic test_reset_defaults();
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shffff);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
    send_sample(16'sh0000);
  endtask

  // all registers at their lowest, then at their highest
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_UNUSED, '1);
    set_config(0, 0, 0, 0, 0);
    send_sample(16'sh0001);
    send_sample(16'shffff);
    send_sample(16'sh0000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    wait_idle();
    // upper data bits beyond the block length field are dropped
    set_config(32767, 32767, 32767, 255, 255);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(16'shffff);
    send_sample(16'sh0000);
    send_sample(16'sd20000);
    send_sample(-16'sd20000);
    send_sample(16'sd12345);
  endtask

  // gain rise, long silence to saturate the silent-block count, then a fast onset
  task automatic test_silence_and_decay();
    wait_idle();
    set_config(1, 1000, 32767, 5, 3);
    repeat (12) send_sample(with_sign($urandom_range(1500, 3000)));
    repeat (270) send_sample(with_sign($urandom_range(0, 1000)));
    repeat (12) send_sample(with_sign($urandom_range(4000, 8000)));
  endtask

  // every sample clips so the block update stays pending, with no idling
  task automatic test_clip_run();
    wait_idle();
    idle_pct = 0;
    set_config(5, 800, 0, 20, 40);
    repeat (60) send_sample(with_sign($urandom_range(1, 32767)));
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    send_sample(16'sd7);
    wait_idle();
    idle_pct = 35;
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    set_config(3, 500, 30000, 2, 4);
    @(posedge clk);
    stall_hold = 400;
    @(negedge clk);
    repeat (24) send_sample(with_sign($urandom_range(0, 32767)));
  endtask

  // bursts of silence and speech under random and fixed settings
  task automatic test_random_traffic();
    int sent;
    int burst;
    int kind;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0, 1: set_config($urandom_range(1, 8), $urandom_range(200, 3000),
                         $urandom_range(16000, 32767), $urandom_range(0, 6),
                         $urandom_range(0, 12));
        2: set_config($urandom_range(0, 64), $urandom_range(0, 32767),
                      $urandom_range(0, 32767), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        default: set_config(2, 800, 32000, 1, 2);
      endcase
      sent = 0;
      while (sent < 65) begin
        burst = $urandom_range(1, 3 * int'(len_reg) + 1);
        if (burst > 40) burst = 40;
        kind = $urandom_range(9);
        repeat (burst) begin
          case (kind)
            0, 1, 2, 3: send_sample(with_sign($urandom_range(0, int'(speech_reg))));
            4, 5, 6: send_sample(with_sign($urandom_range(int'(speech_reg), 32767)));
            7: send_sample(agc_pkg::SAMPLE_W'($urandom));
            8: send_sample(edge_sample());
            default: send_sample(with_sign($urandom_range(0, 32767)));
          endcase
          sent++;
        end
      end
    end
  endtask

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_out.size() == 0) begin
        $display("%t unexpected output: expected none actual %0d", $time, out_sample_out);
        errors++;
      end else begin
        want_sample = expected_out.pop_front();
        if (out_sample_out !== want_sample) begin
          $display("%t sample_out mismatch: expected %0d actual %0d",
                   $time, want_sample, out_sample_out);
          errors++;
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_silence_and_decay();
    test_clip_run();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
